### rtl/core/pel_pkg.sv
// shared constants, codes and control structs of the positional list engine
package pel_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;

  localparam int CMD_W  = 4;
  localparam int POS_W  = 5;
  localparam int ITEM_W = 32;
  localparam int LEN_W  = 5;
  localparam int ELEM_W = 32;
  localparam int STAT_W = 3;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int XW    = (DATA_W > ITEM_W) ? DATA_W : ITEM_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 4'd0,
    CMD_PREPEND = 4'd1,
    CMD_INSERT  = 4'd2,
    CMD_POP     = 4'd3,
    CMD_SHIFT   = 4'd4,
    CMD_OREMOVE = 4'd5,
    CMD_SREMOVE = 4'd6,
    CMD_SETLEN  = 4'd7,
    CMD_EXPAND  = 4'd8,
    CMD_FIRST   = 4'd9,
    CMD_LAST    = 4'd10
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_INDEX  = 3'd3,
    ST_LENGTH = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_REMOVE,
    OP_MOVE,
    OP_SETLEN,
    OP_EXPAND
  } op_t;

  typedef enum logic [1:0] {
    IX_ZERO,
    IX_LAST,
    IX_FILL,
    IX_POS
  } ix_sel_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    ix_sel_t rd_sel;
    ix_sel_t wr_sel;
    op_t     op;
    logic    st_en;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic ok;
  } dp_stat_t;

endpackage

### rtl/core/pel_ctrl.sv
// sequencer of the positional list engine: handshakes and datapath commands
module pel_ctrl
  import pel_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '{load: 1'b0, rd_en: 1'b0, rd_sel: IX_ZERO, wr_sel: IX_ZERO,
                      op: OP_NOP, st_en: 1'b0, out_load: 1'b0};
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.st_en = 1'b1;
        state_nxt = S_FINISH;
        if (stat.ok) begin
          case (stat.cmd)
            CMD_APPEND: begin
              cmd.op     = OP_INSERT;
              cmd.wr_sel = IX_FILL;
            end
            CMD_PREPEND: begin
              cmd.op     = OP_INSERT;
              cmd.wr_sel = IX_ZERO;
            end
            CMD_INSERT: begin
              cmd.op     = OP_INSERT;
              cmd.wr_sel = IX_POS;
            end
            CMD_POP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_LAST;
              cmd.op     = OP_REMOVE;
              cmd.wr_sel = IX_LAST;
            end
            CMD_SHIFT: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_ZERO;
              cmd.op     = OP_REMOVE;
              cmd.wr_sel = IX_ZERO;
            end
            CMD_OREMOVE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_POS;
              cmd.op     = OP_REMOVE;
              cmd.wr_sel = IX_POS;
            end
            CMD_SREMOVE: begin
              // grab the removed element now, fill the hole next cycle
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_POS;
              state_nxt  = S_SWAP;
            end
            CMD_SETLEN: cmd.op = OP_SETLEN;
            CMD_EXPAND: cmd.op = OP_EXPAND;
            CMD_FIRST: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_ZERO;
            end
            CMD_LAST: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = IX_LAST;
            end
            default: ;
          endcase
        end
      end
      S_SWAP: begin
        cmd.rd_sel = IX_LAST;
        cmd.op     = OP_MOVE;
        cmd.wr_sel = IX_POS;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted item did not start execution");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |-> $past(state_r) == S_EXEC && $past(stat.cmd) == CMD_SREMOVE)
    else $error("swap step without swap remove");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state_r == S_FINISH && out_free)
    else $error("result loaded over an untaken result");

endmodule

### rtl/core/pel_dpath.sv
// datapath of the positional list engine: entry registers, fill count, checks, result
module pel_dpath
  import pel_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [POS_W-1:0]     in_position,
  input  logic [ITEM_W-1:0]    in_item_value,
  input  logic [LEN_W-1:0]     in_target_length,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [ELEM_W-1:0]    out_element_out,
  output logic [LEN_W-1:0]     out_length_after,
  output logic [STAT_W-1:0]    out_status
);

  cmd_t                cmd_r;
  logic [POS_W-1:0]    pos_r;
  logic [DATA_W-1:0]   item_r;
  logic [LEN_W-1:0]    tlen_r;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [DATA_W-1:0]   entry_r [DEPTH];
  logic [DATA_W-1:0]   entry_nxt [DEPTH];
  logic [DATA_W-1:0]   up_src [DEPTH];
  logic [DATA_W-1:0]   dn_src [DEPTH];
  logic [DATA_W-1:0]   elem_r;
  status_t             status_r, status_c;
  logic [ELEM_W-1:0]   out_elem_r;
  logic [LEN_W-1:0]    out_len_r;
  status_t             out_status_r;

  logic [CMP_W-1:0]    fill_c, pos_c, tlen_c, ins_at, rd_at, wr_at;
  logic [IDX_W-1:0]    rd_idx;
  logic [DATA_W-1:0]   rd_data;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  assign fill_c = CMP_W'(fill_r);
  assign pos_c  = CMP_W'(pos_r);
  assign tlen_c = CMP_W'(tlen_r);

  function automatic logic [CMP_W-1:0] sel_index(ix_sel_t sel, logic [CMP_W-1:0] fill,
                                                 logic [CMP_W-1:0] pos);
    logic [CMP_W-1:0] r;
    case (sel)
      IX_ZERO: r = '0;
      IX_LAST: r = fill - CMP_W'(1);
      IX_FILL: r = fill;
      IX_POS:  r = pos;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign rd_at   = sel_index(cmd.rd_sel, fill_c, pos_c);
  assign wr_at   = sel_index(cmd.wr_sel, fill_c, pos_c);
  assign rd_idx  = rd_at[IDX_W-1:0];
  assign rd_data = entry_r[rd_idx];

  // neighbor taps for the parallel move up and move down
  for (genvar g = 0; g < DEPTH; g++) begin : g_taps
    if (g == 0) begin : g_lo
      assign up_src[g] = entry_r[g];
    end else begin : g_up
      assign up_src[g] = entry_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign dn_src[g] = entry_r[g];
    end else begin : g_dn
      assign dn_src[g] = entry_r[g+1];
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_APPEND:  ins_at = fill_c;
      CMD_INSERT:  ins_at = pos_c;
      default:     ins_at = '0;
    endcase
  end

  always_comb begin
    status_c = ST_OK;
    case (cmd_r)
      CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
        if (ins_at > fill_c)        status_c = ST_INDEX;
        else if (fill_c >= DEPTH_C) status_c = ST_FULL;
      end
      CMD_POP, CMD_SHIFT, CMD_FIRST, CMD_LAST: begin
        if (fill_c == '0) status_c = ST_EMPTY;
      end
      CMD_OREMOVE, CMD_SREMOVE: begin
        if (fill_c == '0)          status_c = ST_EMPTY;
        else if (pos_c >= fill_c)  status_c = ST_INDEX;
      end
      CMD_SETLEN: begin
        if (tlen_c > DEPTH_C) status_c = ST_LENGTH;
      end
      default: status_c = ST_OK;
    endcase
  end

  assign stat.cmd = cmd_r;
  assign stat.ok  = (status_c == ST_OK);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_nxt[i] = entry_r[i];
      case (cmd.op)
        OP_INSERT: begin
          if (CMP_W'(i) == wr_at) begin
            entry_nxt[i] = item_r;
          end else if (CMP_W'(i) > wr_at && CMP_W'(i) <= fill_c) begin
            entry_nxt[i] = up_src[i];
          end
        end
        OP_REMOVE: begin
          if (CMP_W'(i) >= wr_at && CMP_W'(i + 1) < fill_c) begin
            entry_nxt[i] = dn_src[i];
          end
        end
        OP_MOVE: begin
          if (CMP_W'(i) == wr_at) entry_nxt[i] = rd_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_INSERT:          fill_nxt = fill_r + CNT_W'(1);
      OP_REMOVE, OP_MOVE: fill_nxt = fill_r - CNT_W'(1);
      OP_SETLEN:          fill_nxt = CNT_W'(tlen_r);
      OP_EXPAND:          fill_nxt = CNT_W'(DEPTH);
      default:            fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int i = 0; i < DEPTH; i++) entry_r[i] <= '0;
    end else begin
      fill_r <= fill_nxt;
      for (int i = 0; i < DEPTH; i++) entry_r[i] <= entry_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= cmd_t'(in_command);
      pos_r  <= in_position;
      item_r <= DATA_W'(XW'(in_item_value));
      tlen_r <= in_target_length;
      elem_r <= '0;
    end else if (cmd.rd_en) begin
      elem_r <= rd_data;
    end
    if (cmd.st_en) status_r <= status_c;
    if (cmd.out_load) begin
      out_elem_r   <= ELEM_W'(XW'(elem_r));
      out_len_r    <= LEN_W'(fill_c);
      out_status_r <= status_r;
    end
  end

  assign out_element_out  = out_elem_r;
  assign out_length_after = out_len_r;
  assign out_status       = out_status_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_c <= DEPTH_C)
    else $error("fill count above capacity");

  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_en && status_c != ST_OK |=> fill_r == $past(fill_r))
    else $error("failed command changed the fill count");

endmodule

### rtl/core/positional_list_engine.sv
// top level of the positional list engine: bounded list used as a deque
//
//   port group    dir   handshake             payload
//   in_*          in    in_valid / in_stall   command, position, item_value, target_length
//   out_*         out   out_valid / out_stall element_out, length_after, status
//
// after the accepting edge, the entry registers are checked and updated, then the result
// register loads once no untaken result is held at out_*; swap remove reads the last
// entry through the single read port in an extra step before the result load.
// in_stall stays high until the result is loaded, so no new item is taken meanwhile.
// the next item is accepted once the result is loaded, even while it waits at out_*.
// synchronous active-low reset clears the fill count and every entry.
module positional_list_engine
  import pel_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [POS_W-1:0]   in_position,
  input  logic [ITEM_W-1:0]  in_item_value,
  input  logic [LEN_W-1:0]   in_target_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ELEM_W-1:0]  out_element_out,
  output logic [LEN_W-1:0]   out_length_after,
  output logic [STAT_W-1:0]  out_status
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  pel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  pel_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .in_target_length (in_target_length),
    .cmd              (dp_cmd),
    .stat             (dp_stat),
    .out_element_out  (out_element_out),
    .out_length_after (out_length_after),
    .out_status       (out_status)
  );

endmodule
